// ===== src/pdkr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdkr_pkg: shared types and constants for the pad debounce / key repeat block
// Field widths, register indexes, scan prefix and tick arithmetic helpers.
// ----------------------------------------------------------------------------
package pdkr_pkg;

  // tick counter width inside the block
  localparam int TICK_BITS = 32;

  // field widths
  localparam int PKT_BITS_W  = 7;
  localparam int WORD_W      = 32;
  localparam int BTN_W       = 13;
  localparam int DELAY_W     = 16;
  localparam int COUNT_W     = 8;
  localparam int EXT_TICK_W  = 32;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 48;

  // configuration port
  localparam int CFG_ADDR_W  = 8;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PACKET_BITS = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_MASK     = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION_MASK  = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_DELAY    = 8'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOW_PERIOD     = 8'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FAST_PERIOD     = 8'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOW_REPEATS    = 8'd6;

  // register reset values
  localparam logic [PKT_BITS_W-1:0] RST_MIN_PACKET_BITS = 7'd90;
  localparam logic [BTN_W-1:0]      RST_BUTTON_MASK     = 13'd8063;
  localparam logic [BTN_W-1:0]      RST_DIRECTION_MASK  = 13'd15;
  localparam logic [DELAY_W-1:0]    RST_REPEAT_DELAY    = 16'd30;
  localparam logic [DELAY_W-1:0]    RST_SLOW_PERIOD     = 16'd6;
  localparam logic [DELAY_W-1:0]    RST_FAST_PERIOD     = 16'd1;
  localparam logic [COUNT_W-1:0]    RST_SLOW_REPEATS    = 8'd20;

  // packet header check and button position
  localparam logic [WORD_W-1:0] SCAN_MASK    = 32'hfffff0f0;
  localparam logic [WORD_W-1:0] SCAN_PREFIX  = 32'h01000000;
  localparam int                BUTTON_SHIFT = 17;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [BTN_W-1:0]     btn_t;

  // true when tick a lies strictly after tick b, with wraparound
  function automatic logic tick_after(input tick_t a, input tick_t b);
    tick_t d;
    d = b - a;
    return d[TICK_BITS-1];
  endfunction

endpackage

// ===== src/pad_debounce_key_repeat.sv =====
// ----------------------------------------------------------------------------
// pad_debounce_key_repeat: controller button debouncer with auto repeat
// Filters received pad packets, debounces the button set over two samples,
// publishes changes with their tick and raises timed repeat events.
// ----------------------------------------------------------------------------
// The result of an accepted input transaction is registered and shown in the cycle after it.
// Throughput: one transaction per cycle; the single output register lets
// the next packet in whenever the current result is taken in the same cycle.
// State update and result come from one pass of compare/add logic per packet.
// Reset (rst, synchronous): registers return to their defaults, all tracking
// state clears to zero and the output channel goes empty.
module pad_debounce_key_repeat (
  input  logic                                clk,
  input  logic                                rst,
  // input stream, tdata fields from bit 0 up:
  // packet_bits[6:0], header_word[38:7], button_word[70:39], now_tick[102:71]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pdkr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // result stream, tdata fields from bit 0 up:
  // buttons[12:0], changed[13], repeat_fire[14], last_change_tick[46:15]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pdkr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdkr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pdkr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pdkr_pkg::*;

  // configuration registers
  logic [PKT_BITS_W-1:0] min_packet_bits;
  btn_t                  button_mask;
  btn_t                  direction_mask;
  logic [DELAY_W-1:0]    repeat_delay;
  logic [DELAY_W-1:0]    slow_period;
  logic [DELAY_W-1:0]    fast_period;
  logic [COUNT_W-1:0]    slow_repeats;

  // tracking state
  tick_t                 last_seen_tick, last_seen_tick_next;
  btn_t                  previous_sample, previous_sample_next;
  btn_t                  held_buttons, held_buttons_next;
  tick_t                 repeat_due_tick, repeat_due_tick_next;
  logic [COUNT_W-1:0]    slow_left, slow_left_next;
  tick_t                 change_time, change_time_next;

  // output register
  btn_t                  out_buttons;
  logic                  out_changed;
  logic                  out_fire;
  logic [EXT_TICK_W-1:0] out_change_tick;

  // input field unpacking
  logic [PKT_BITS_W-1:0] in_packet_bits;
  logic [WORD_W-1:0]     in_header_word;
  logic [WORD_W-1:0]     in_button_word;
  tick_t                 now;
  logic [WORD_W-1:0]     shifted_word;
  btn_t                  sample;
  logic                  in_accept;
  logic                  packet_ok;
  logic                  changed_next;
  logic                  fire_next;

  assign in_packet_bits = s_axis_tdata[6:0];
  assign in_header_word = s_axis_tdata[38:7];
  assign in_button_word = s_axis_tdata[70:39];
  assign now            = TICK_BITS'(s_axis_tdata[102:71]);
  assign shifted_word   = in_button_word >> BUTTON_SHIFT;
  assign sample         = shifted_word[BTN_W-1:0] & button_mask;

  // handshakes
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      min_packet_bits <= RST_MIN_PACKET_BITS;
      button_mask     <= RST_BUTTON_MASK;
      direction_mask  <= RST_DIRECTION_MASK;
      repeat_delay    <= RST_REPEAT_DELAY;
      slow_period     <= RST_SLOW_PERIOD;
      fast_period     <= RST_FAST_PERIOD;
      slow_repeats    <= RST_SLOW_REPEATS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_MIN_PACKET_BITS: min_packet_bits <= cfg_data[PKT_BITS_W-1:0];
        REG_BUTTON_MASK:     button_mask     <= cfg_data[BTN_W-1:0];
        REG_DIRECTION_MASK:  direction_mask  <= cfg_data[BTN_W-1:0];
        REG_REPEAT_DELAY:    repeat_delay    <= cfg_data;
        REG_SLOW_PERIOD:     slow_period     <= cfg_data;
        REG_FAST_PERIOD:     fast_period     <= cfg_data;
        REG_SLOW_REPEATS:    slow_repeats    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // packet filter: long enough, scan header, new tick
  assign packet_ok = (in_packet_bits >= min_packet_bits) &&
                     ((in_header_word & SCAN_MASK) == SCAN_PREFIX) &&
                     (now != last_seen_tick);

  // debounce, publish and repeat decision
  always_comb begin
    last_seen_tick_next  = last_seen_tick;
    previous_sample_next = previous_sample;
    held_buttons_next    = held_buttons;
    repeat_due_tick_next = repeat_due_tick;
    slow_left_next       = slow_left;
    change_time_next     = change_time;
    changed_next         = 1'b0;
    fire_next            = 1'b0;
    if (packet_ok) begin
      last_seen_tick_next = now;
      priority if (sample != previous_sample) begin
        previous_sample_next = sample;
      end else if (sample != held_buttons) begin
        held_buttons_next    = sample;
        change_time_next     = now;
        repeat_due_tick_next = now + TICK_BITS'(repeat_delay);
        slow_left_next       = slow_repeats;
        changed_next         = 1'b1;
      end else if (((sample & direction_mask) != '0) &&
                   tick_after(now, repeat_due_tick)) begin
        fire_next = 1'b1;
        if (slow_left != '0) begin
          slow_left_next       = slow_left - 1'b1;
          repeat_due_tick_next = repeat_due_tick + TICK_BITS'(slow_period);
        end else begin
          repeat_due_tick_next = repeat_due_tick + TICK_BITS'(fast_period);
        end
      end
    end
  end

  // state registers, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen_tick  <= '0;
      previous_sample <= '0;
      held_buttons    <= '0;
      repeat_due_tick <= '0;
      slow_left       <= '0;
      change_time     <= '0;
    end else if (in_accept) begin
      last_seen_tick  <= last_seen_tick_next;
      previous_sample <= previous_sample_next;
      held_buttons    <= held_buttons_next;
      repeat_due_tick <= repeat_due_tick_next;
      slow_left       <= slow_left_next;
      change_time     <= change_time_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_buttons     <= held_buttons_next;
      out_changed     <= changed_next;
      out_fire        <= fire_next;
      out_change_tick <= EXT_TICK_W'(change_time_next);
    end
  end

  assign m_axis_tdata = {1'b0, out_change_tick, out_fire, out_changed, out_buttons};

  // a result never reports a change and a repeat together
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_changed && out_fire))
    else $error("change and repeat raised together");

  // a published change agrees with the debounce sample it came from
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_changed) |-> (held_buttons == previous_sample &&
                                        out_buttons == held_buttons))
    else $error("published set differs from debounced sample");

  // reset empties the output channel
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a repeat only fires for a held set that has a direction bit
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_fire) |-> ((out_buttons & direction_mask) != '0))
    else $error("repeat without direction button");

endmodule
